[rtl/core/mwap_pkg.sv]
// shared types and constants for the moisture window average core
// no dependencies; every other file imports this package
package mwap_pkg;

    // field widths fixed by the data format
    localparam int RAW_W    = 16;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 12;
    localparam int MOIST_W  = 15;
    localparam int STATUS_W = 2;
    localparam int QUOT_W   = 15;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // one hundred percent times 256
    localparam logic [MOIST_W-1:0] FULL_SCALE = 15'd25600;

    // calibration register reset values
    localparam logic [LEVEL_W-1:0] DRY_RESET = 12'hFFF;
    localparam logic [LEVEL_W-1:0] WET_RESET = 12'h000;

    // register index, taken from paddr bit 2
    localparam logic REG_DRY = 1'b0;
    localparam logic REG_WET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_CAL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PRODUCT,
        ST_SIGN,
        ST_SCALE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

[rtl/core/mwap_if.sv]
// request channels of the moisture window average core
// depends on mwap_pkg for field widths
interface mwap_sample_if
    import mwap_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [RAW_W-1:0]   raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface mwap_result_if
    import mwap_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [MOIST_W-1:0]     moisture_x256;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output moisture_x256, output status, input ready);
    modport sink   (input valid, input moisture_x256, input status, output ready);
endinterface

[rtl/core/mwap_cfg.sv]
// apb-style calibration registers: dry and wet levels
// depends on mwap_pkg
module mwap_cfg
    import mwap_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [LEVEL_W-1:0]  dry_level,
    output logic [LEVEL_W-1:0]  wet_level
);

    logic [LEVEL_W-1:0] dry_reg;
    logic [LEVEL_W-1:0] wet_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // register writes, upper data bits dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg <= DRY_RESET;
            wet_reg <= WET_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_DRY)
            begin
                dry_reg <= pwdata[LEVEL_W-1:0];
            end
            else
            begin
                wet_reg <= pwdata[LEVEL_W-1:0];
            end
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_DRY: prdata = DATA_W'(dry_reg);
            REG_WET: prdata = DATA_W'(wet_reg);
            default: prdata = '0;
        endcase
    end

    assign dry_level = dry_reg;
    assign wet_level = wet_reg;

endmodule

[rtl/core/mwap_ring.sv]
// sample window store: one write port, one read port, registered read data
// depends on mwap_pkg
module mwap_ring
    import mwap_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int SLOT_W = 3
)
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [SLOT_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mwap_div.sv]
// restoring divider, one quotient bit per cycle
// expects dividend below divisor shifted up by QUOT_W; depends on mwap_pkg
module mwap_div
    import mwap_pkg::*;
#(
    parameter int DEN_W = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DEN_W+QUOT_W-1:0]     dividend,
    input  logic [DEN_W-1:0]            divisor,
    output logic                        done,
    output logic [QUOT_W-1:0]           quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_next;
    logic [QUOT_W-1:0]  shift_reg;
    logic [QUOT_W-1:0]  shift_next;
    logic [DEN_W-1:0]   den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DEN_W:0]     partial;
    logic [DEN_W:0]     trial;

    // one trial subtraction
    always_comb
    begin
        partial = {rem_reg, shift_reg[QUOT_W-1]};
        trial   = partial - {1'b0, den_reg};
        if (partial >= {1'b0, den_reg})
        begin
            rem_next   = trial[DEN_W-1:0];
            shift_next = {shift_reg[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next   = partial[DEN_W-1:0];
            shift_next = {shift_reg[QUOT_W-2:0], 1'b0};
        end
    end

    // step counter and handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: low dividend bits shift out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= dividend[DEN_W+QUOT_W-1:QUOT_W];
            shift_reg <= dividend[QUOT_W-1:0];
            den_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

[rtl/core/moisture_window_average_percent_core.sv]
// sequence from accept: an out-of-range sample goes straight to done; otherwise update, then
// done for equal levels, else product, sign and scale, then done for a zero or full-scale result,
// else the 15-step divider and then done; one request at a time, the next taken once the result
// loads; a result waiting at the output holds the following one
// reset: rst_n asynchronous, zeroes window sum, fill count and write slot, and sets
// both levels to their defaults; the sample memory is not cleared, only written entries are used
module moisture_window_average_percent_core
    import mwap_pkg::*;
#(
    parameter int WINDOW = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    mwap_sample_if.sink             samples,
    mwap_result_if.source           results,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MAG_W  = SAMPLE_W + CNT_W;
    localparam int PROD_W = MAG_W + QUOT_W;

    state_t                 state_reg;
    state_t                 state_next;
    logic [MAG_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [SLOT_W-1:0]      slot_reg;
    status_t                status_reg;
    logic                   out_valid_reg;
    logic [MOIST_W-1:0]     out_moist_reg;
    status_t                out_status_reg;

    logic [SAMPLE_W-1:0]    sample_reg;
    logic [MAG_W-1:0]       dryfill_reg;
    logic [MAG_W-1:0]       absden_reg;
    logic                   den_neg_reg;
    logic [MAG_W-1:0]       absnum_reg;
    logic                   zero_reg;
    logic                   sat_reg;

    logic [LEVEL_W-1:0]     dry_level;
    logic [LEVEL_W-1:0]     wet_level;
    logic [SAMPLE_W-1:0]    old_sample;
    logic                   accept;
    logic                   raw_bad;
    logic                   window_full;
    logic                   out_free;
    logic                   out_load;
    logic [MAG_W-1:0]       sum_upd;
    logic [LEVEL_W-1:0]     level_diff;
    logic                   num_ge;
    logic [MAG_W-1:0]       absnum;
    logic [PROD_W-1:0]      scaled_num;
    logic                   div_start;
    logic                   div_done;
    logic [QUOT_W-1:0]      div_quot;
    logic [MOIST_W-1:0]     moist_final;

    // calibration registers
    mwap_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .dry_level  (dry_level),
        .wet_level  (wet_level)
    );

    // window memory: read of the slot on accept, write back in update;
    // one request in flight so the two never overlap
    mwap_ring #(
        .DEPTH  (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_ring (
        .clk        (clk),
        .rd_en      (accept),
        .rd_addr    (slot_reg),
        .rd_data    (old_sample),
        .wr_en      (state_reg == ST_UPDATE),
        .wr_addr    (slot_reg),
        .wr_data    (sample_reg)
    );

    // scaling divider
    mwap_div #(
        .DEN_W (MAG_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (scaled_num),
        .divisor    (absden_reg),
        .done       (div_done),
        .quotient   (div_quot)
    );

    // handshake and window arithmetic
    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign raw_bad       = |samples.raw_sample[RAW_W-1:SAMPLE_W];
    assign window_full   = (fill_reg == CNT_W'(WINDOW));
    assign out_free      = !out_valid_reg || results.ready;
    assign out_load      = (state_reg == ST_DONE) && out_free;
    assign sum_upd       = sum_reg - (window_full ? MAG_W'(old_sample) : '0)
                           + MAG_W'(sample_reg);
    assign level_diff    = (dry_level >= wet_level) ? (dry_level - wet_level)
                                                    : (wet_level - dry_level);
    assign num_ge        = (dryfill_reg >= sum_reg);
    assign absnum        = num_ge ? (dryfill_reg - sum_reg) : (sum_reg - dryfill_reg);
    assign scaled_num    = PROD_W'(absnum_reg) * PROD_W'(FULL_SCALE);
    assign div_start     = (state_reg == ST_SCALE) && !zero_reg && !sat_reg;

    // result selection
    always_comb
    begin
        priority if (status_reg != STATUS_OK)
        begin
            moist_final = '0;
        end
        else if (zero_reg)
        begin
            moist_final = '0;
        end
        else if (sat_reg)
        begin
            moist_final = FULL_SCALE;
        end
        else
        begin
            moist_final = div_quot;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = raw_bad ? ST_DONE : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = (dry_level == wet_level) ? ST_DONE : ST_PRODUCT;
            end
            ST_PRODUCT:
            begin
                state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = (zero_reg || sat_reg) ? ST_DONE : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && raw_bad)
            begin
                status_reg <= STATUS_RANGE;
            end
            if (state_reg == ST_UPDATE)
            begin
                sum_reg    <= sum_upd;
                status_reg <= (dry_level == wet_level) ? STATUS_CAL : STATUS_OK;
                if (!window_full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (slot_reg == SLOT_W'(WINDOW - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= samples.raw_sample[SAMPLE_W-1:0];
        end
        if (state_reg == ST_PRODUCT)
        begin
            dryfill_reg <= MAG_W'(dry_level) * MAG_W'(fill_reg);
            absden_reg  <= MAG_W'(level_diff) * MAG_W'(fill_reg);
            den_neg_reg <= (dry_level < wet_level);
        end
        if (state_reg == ST_SIGN)
        begin
            absnum_reg <= absnum;
            zero_reg   <= (dryfill_reg == sum_reg) || ((!num_ge) != den_neg_reg);
            sat_reg    <= (absnum >= absden_reg);
        end
        if (out_load)
        begin
            out_moist_reg  <= moist_final;
            out_status_reg <= status_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.moisture_x256 = out_moist_reg;
    assign results.status        = out_status_reg;

    // window bookkeeping stays in range
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count above window length");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot beyond window");

    // a rejected sample leaves the window untouched
    a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && raw_bad) |=> ($stable(sum_reg) && $stable(fill_reg) && $stable(slot_reg)))
        else $error("rejected sample changed window state");

    // loaded result never exceeds full scale and is zero on error
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_moist_reg <= FULL_SCALE) &&
                     ((out_status_reg == STATUS_OK) || (out_moist_reg == '0)))
        else $error("result out of range");

endmodule
